FILE: sv/h2r_pkg.sv
package h2r_pkg;

    localparam int HUE_W  = 16;
    localparam int PCT_W  = 7;
    localparam int PIX_W  = 16;
    localparam int CH_W   = 5;
    localparam int REM_W  = 14;
    localparam int QUO_W  = 7;
    localparam int SEXT_W = 3;

    localparam logic [PCT_W-1:0] PCT_MAX  = 7'd100;
    localparam logic [PCT_W-1:0] PCT_HALF = 7'd50;

    localparam logic [13:0] HUE_RECIP    = 14'd11651;
    localparam int          HUE_SHIFT    = 22;
    localparam logic [12:0] DIV100_RECIP = 13'd5243;
    localparam int          DIV100_SHIFT = 19;
    localparam logic [10:0] SEXT_RECIP   = 11'd1093;
    localparam int          SEXT_SHIFT   = 16;
    localparam logic [9:0]  THIRD_RECIP  = 10'd683;
    localparam int          THIRD_SHIFT  = 11;
    localparam logic [20:0] VSF_RECIP    = 21'd1717987;
    localparam int          VSF_SHIFT    = 34;

    typedef struct packed {
        logic [PCT_W-1:0]  v;
        logic [PCT_W-1:0]  m;
        logic [SEXT_W-1:0] sext;
        logic [PCT_W-1:0]  fract;
        logic              alpha;
    } t_side;

    function automatic logic [CH_W-1:0] chan5(input logic [PCT_W-1:0] pct);
        logic [11:0] scaled;
        logic [24:0] prod;
        scaled = 12'(pct) * 12'd31;
        prod   = 25'(scaled) * 25'(DIV100_RECIP);
        return prod[DIV100_SHIFT+CH_W-1:DIV100_SHIFT];
    endfunction

endpackage

FILE: sv/h2r_front.sv
module h2r_front import h2r_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [HUE_W-1:0]  i_hue_deg,
    input  logic [PCT_W-1:0]  i_saturation_pct,
    input  logic [PCT_W-1:0]  i_lightness_pct,
    input  logic              i_alpha_bit,
    output logic              o_en,
    input  logic              i_en_dn,
    output logic              o_vld,
    output logic [REM_W-1:0]  o_num,
    output logic [REM_W-1:0]  o_dsh,
    output t_side             o_side
);

    logic en1, en2, en3, en4;

    logic              r_s1_vld, r_s1_alpha;
    logic [HUE_W-1:0]  r_s1_hue;
    logic [7:0]        r_s1_q;
    logic [PCT_W-1:0]  r_s1_sat, r_s1_lum;
    logic [14:0]       r_s1_p1;
    logic [13:0]       r_s1_p2;

    logic              r_s2_vld, r_s2_alpha;
    logic [8:0]        r_s2_hh;
    logic [PCT_W-1:0]  r_s2_sat, r_s2_lum, r_s2_d1, r_s2_d2;

    logic              r_s3_vld, r_s3_alpha;
    logic [8:0]        r_s3_hh;
    logic [SEXT_W-1:0] r_s3_sext;
    logic [PCT_W-1:0]  r_s3_v, r_s3_m;
    logic [REM_W-1:0]  r_s3_num;

    logic              r_s4_vld;
    logic [REM_W-1:0]  r_s4_num, r_s4_dsh;
    t_side             r_s4_side;

    logic [PCT_W-1:0]  n_s1_sat, n_s1_lum;
    logic [7:0]        n_s1_sat8;
    logic [29:0]       n_s1_hprod;
    logic [8:0]        n_s2_hh;
    logic [27:0]       n_s2_prod1, n_s2_prod2;
    logic [PCT_W-1:0]  n_s3_v, n_s3_m;
    logic [19:0]       n_s3_sprod;
    logic [5:0]        n_s4_r60;
    logic [8:0]        n_s4_x5;
    logic [18:0]       n_s4_fprod;

    assign en4  = !r_s4_vld || i_en_dn;
    assign en3  = !r_s3_vld || en4;
    assign en2  = !r_s2_vld || en3;
    assign en1  = !r_s1_vld || en2;
    assign o_en = en1;

    always_comb begin
        n_s1_sat   = (i_saturation_pct > PCT_MAX) ? PCT_MAX : i_saturation_pct;
        n_s1_lum   = (i_lightness_pct > PCT_MAX) ? PCT_MAX : i_lightness_pct;
        n_s1_sat8  = 8'(n_s1_sat) + 8'(PCT_MAX);
        n_s1_hprod = 30'(i_hue_deg) * 30'(HUE_RECIP);

        n_s2_hh    = 9'(r_s1_hue - 16'(r_s1_q) * 16'd360);
        n_s2_prod1 = 28'(r_s1_p1) * 28'(DIV100_RECIP);
        n_s2_prod2 = 28'(r_s1_p2) * 28'(DIV100_RECIP);

        if (r_s2_lum < PCT_HALF) begin
            n_s3_v = r_s2_d1;
        end else begin
            n_s3_v = 7'(8'(r_s2_lum) + 8'(r_s2_sat) - 8'(r_s2_d2));
        end
        n_s3_m     = 7'({1'b0, r_s2_lum, 1'b0} - 9'(n_s3_v));
        n_s3_sprod = 20'(r_s2_hh) * 20'(SEXT_RECIP);

        n_s4_r60   = 6'(r_s3_hh - 9'(r_s3_sext) * 9'd60);
        n_s4_x5    = 9'(n_s4_r60) * 9'd5;
        n_s4_fprod = 19'(n_s4_x5) * 19'(THIRD_RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else begin
            if (en1) begin
                r_s1_vld <= i_vld;
            end
            if (en2) begin
                r_s2_vld <= r_s1_vld;
            end
            if (en3) begin
                r_s3_vld <= r_s2_vld;
            end
            if (en4) begin
                r_s4_vld <= r_s3_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_hue   <= i_hue_deg;
            r_s1_q     <= n_s1_hprod[HUE_SHIFT+7:HUE_SHIFT];
            r_s1_sat   <= n_s1_sat;
            r_s1_lum   <= n_s1_lum;
            r_s1_alpha <= i_alpha_bit;
            r_s1_p1    <= 15'(n_s1_lum) * 15'(n_s1_sat8);
            r_s1_p2    <= 14'(n_s1_lum) * 14'(n_s1_sat);
        end
        if (en2) begin
            r_s2_hh    <= n_s2_hh;
            r_s2_sat   <= r_s1_sat;
            r_s2_lum   <= r_s1_lum;
            r_s2_alpha <= r_s1_alpha;
            r_s2_d1    <= n_s2_prod1[DIV100_SHIFT+PCT_W-1:DIV100_SHIFT];
            r_s2_d2    <= n_s2_prod2[DIV100_SHIFT+PCT_W-1:DIV100_SHIFT];
        end
        if (en3) begin
            r_s3_hh    <= r_s2_hh;
            r_s3_sext  <= n_s3_sprod[SEXT_SHIFT+SEXT_W-1:SEXT_SHIFT];
            r_s3_v     <= n_s3_v;
            r_s3_m     <= n_s3_m;
            r_s3_num   <= REM_W'(n_s3_v - n_s3_m) * REM_W'(PCT_MAX);
            r_s3_alpha <= r_s2_alpha;
        end
        if (en4) begin
            r_s4_num        <= r_s3_num;
            r_s4_dsh        <= REM_W'(r_s3_v) << (QUO_W - 1);
            r_s4_side.v     <= r_s3_v;
            r_s4_side.m     <= r_s3_m;
            r_s4_side.sext  <= r_s3_sext;
            r_s4_side.fract <= n_s4_fprod[THIRD_SHIFT+PCT_W-1:THIRD_SHIFT];
            r_s4_side.alpha <= r_s3_alpha;
        end
    end

    assign o_vld  = r_s4_vld;
    assign o_num  = r_s4_num;
    assign o_dsh  = r_s4_dsh;
    assign o_side = r_s4_side;

    a_floor_below_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_vld |-> (r_s3_m <= r_s3_v))
        else $error("Floor value exceeds peak value.");

endmodule

FILE: sv/h2r_div_cell.sv
module h2r_div_cell import h2r_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [REM_W-1:0]  i_rem,
    input  logic [REM_W-1:0]  i_dsh,
    input  logic [QUO_W-1:0]  i_quo,
    input  t_side             i_side,
    input  logic              i_en_dn,
    output logic              o_en,
    output logic              o_vld,
    output logic [REM_W-1:0]  o_rem,
    output logic [REM_W-1:0]  o_dsh,
    output logic [QUO_W-1:0]  o_quo,
    output t_side             o_side
);

    logic              en;
    logic              fits;
    logic              r_vld;
    logic [REM_W-1:0]  r_rem, r_dsh, n_rem;
    logic [QUO_W-1:0]  r_quo;
    t_side             r_side;

    assign en   = !r_vld || i_en_dn;
    assign o_en = en;

    assign fits  = (i_rem >= i_dsh);
    assign n_rem = fits ? (i_rem - i_dsh) : i_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rem  <= n_rem;
            r_dsh  <= i_dsh >> 1;
            r_quo  <= {i_quo[QUO_W-2:0], fits};
            r_side <= i_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_rem  = r_rem;
    assign o_dsh  = r_dsh;
    assign o_quo  = r_quo;
    assign o_side = r_side;

endmodule

FILE: sv/h2r_back.sv
module h2r_back import h2r_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [QUO_W-1:0]  i_sv,
    input  t_side             i_side,
    output logic              o_en,
    input  logic              i_ready,
    output logic              o_valid,
    output logic [PIX_W-1:0]  o_pixel_word
);

    logic enA, enB, enC, enD;

    logic              r_a_vld, r_b_vld, r_c_vld, r_d_vld;
    logic [13:0]       r_a_p;
    logic [20:0]       r_b_x;
    logic [PCT_W-1:0]  r_c_vsf;
    t_side             r_a_side, r_b_side, r_c_side;
    logic [PIX_W-1:0]  r_d_pix;

    logic [41:0]       n_vprod;
    logic [PCT_W-1:0]  n_mid1, n_mid2, n_r, n_g, n_b;
    logic [PIX_W-1:0]  n_pix;

    assign enD  = !r_d_vld || i_ready;
    assign enC  = !r_c_vld || enD;
    assign enB  = !r_b_vld || enC;
    assign enA  = !r_a_vld || enB;
    assign o_en = enA;

    assign n_vprod = 42'(r_b_x) * 42'(VSF_RECIP);

    always_comb begin
        n_mid1 = r_c_side.m + r_c_vsf;
        n_mid2 = r_c_side.v - r_c_vsf;
        case (r_c_side.sext)
            3'd0: begin
                n_r = r_c_side.v; n_g = n_mid1;     n_b = r_c_side.m;
            end
            3'd1: begin
                n_r = n_mid2;     n_g = r_c_side.v; n_b = r_c_side.m;
            end
            3'd2: begin
                n_r = r_c_side.m; n_g = r_c_side.v; n_b = n_mid1;
            end
            3'd3: begin
                n_r = r_c_side.m; n_g = n_mid2;     n_b = r_c_side.v;
            end
            3'd4: begin
                n_r = n_mid1;     n_g = r_c_side.m; n_b = r_c_side.v;
            end
            default: begin
                n_r = r_c_side.v; n_g = r_c_side.m; n_b = n_mid2;
            end
        endcase
        if (r_c_side.v == '0) begin
            n_pix = {r_c_side.alpha, {(3*CH_W){1'b0}}};
        end else begin
            n_pix = {r_c_side.alpha, chan5(n_b), chan5(n_g), chan5(n_r)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else begin
            if (enA) begin
                r_a_vld <= i_vld;
            end
            if (enB) begin
                r_b_vld <= r_a_vld;
            end
            if (enC) begin
                r_c_vld <= r_b_vld;
            end
            if (enD) begin
                r_d_vld <= r_c_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (enA) begin
            r_a_p    <= 14'(i_sv) * 14'(i_side.v);
            r_a_side <= i_side;
        end
        if (enB) begin
            r_b_x    <= 21'(r_a_p) * 21'(r_a_side.fract);
            r_b_side <= r_a_side;
        end
        if (enC) begin
            r_c_vsf  <= n_vprod[VSF_SHIFT+PCT_W-1:VSF_SHIFT];
            r_c_side <= r_b_side;
        end
        if (enD) begin
            r_d_pix  <= n_pix;
        end
    end

    assign o_valid      = r_d_vld;
    assign o_pixel_word = r_d_pix;

    a_sv_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_vld && (i_side.v != '0)) |-> (i_sv <= PCT_MAX))
        else $error("Saturation of value exceeds one hundred.");

    a_ramp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_vld |-> ((8'(r_c_vsf) + 8'(r_c_side.m)) <= 8'(r_c_side.v)))
        else $error("Ramp term exceeds the spread between peak and floor.");

endmodule

FILE: sv/hsl_to_rgb555.sv
// Channel  Direction  Handshake            Payload
// input    in         i_valid / o_ready    i_hue_deg, i_saturation_pct, i_lightness_pct,
//                                          i_alpha_bit
// output   out        o_valid / i_ready    o_pixel_word
//
// One item is taken per clock while o_ready is high.
// The pipeline is the seven-cell divider chain that forms saturation of value,
// one quotient bit per cell, between four front and four back stages.
// Reset, synchronous and active low, clears only the valid bits of the stages.
// Each stage holds while it is full and its successor holds, so bubbles close up and input is
// refused only when every stage holds a transaction.
module hsl_to_rgb555 import h2r_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [HUE_W-1:0]  i_hue_deg,
    input  logic [PCT_W-1:0]  i_saturation_pct,
    input  logic [PCT_W-1:0]  i_lightness_pct,
    input  logic              i_alpha_bit,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [PIX_W-1:0]  o_pixel_word
);

    logic              c_vld [0:QUO_W];
    logic              c_en  [0:QUO_W];
    logic [REM_W-1:0]  c_rem [0:QUO_W];
    logic [REM_W-1:0]  c_dsh [0:QUO_W];
    logic [QUO_W-1:0]  c_quo [0:QUO_W];
    t_side             c_side[0:QUO_W];

    assign c_quo[0] = '0;

    h2r_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_vld            (i_valid),
        .i_hue_deg        (i_hue_deg),
        .i_saturation_pct (i_saturation_pct),
        .i_lightness_pct  (i_lightness_pct),
        .i_alpha_bit      (i_alpha_bit),
        .o_en             (o_ready),
        .i_en_dn          (c_en[0]),
        .o_vld            (c_vld[0]),
        .o_num            (c_rem[0]),
        .o_dsh            (c_dsh[0]),
        .o_side           (c_side[0])
    );

    for (genvar k = 0; k < QUO_W; k++) begin : g_cell
        h2r_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (c_vld[k]),
            .i_rem   (c_rem[k]),
            .i_dsh   (c_dsh[k]),
            .i_quo   (c_quo[k]),
            .i_side  (c_side[k]),
            .i_en_dn (c_en[k+1]),
            .o_en    (c_en[k]),
            .o_vld   (c_vld[k+1]),
            .o_rem   (c_rem[k+1]),
            .o_dsh   (c_dsh[k+1]),
            .o_quo   (c_quo[k+1]),
            .o_side  (c_side[k+1])
        );
    end

    h2r_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vld        (c_vld[QUO_W]),
        .i_sv         (c_quo[QUO_W]),
        .i_side       (c_side[QUO_W]),
        .o_en         (c_en[QUO_W]),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_pixel_word (o_pixel_word)
    );

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("Input refused while the output stage can move.");

endmodule
